// ===== sv/ttps_pkg.sv =====
package ttps_pkg;

   typedef enum logic [1:0] {
      ACT_STORE      = 2'd0,
      ACT_PROBE      = 2'd1,
      ACT_NEW_SEARCH = 2'd2,
      ACT_MATCH_MOVE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_EXACT = 2'd1,
      KIND_LOWER = 2'd2,
      KIND_UPPER = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_READ  = 5'b01000,
      ST_EXEC  = 5'b10000
   } state_type;

   localparam int KEY_W   = 64;
   localparam int DEPTH_W = 8;
   localparam int SCORE_W = 16;
   localparam int MOVE_W  = 16;
   localparam int GEN_W   = 8;
   localparam int CHUNK_CNT_W = 3;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
      kind_type           kind;
      logic [MOVE_W-1:0]  mv;
      logic [DEPTH_W-1:0] depth;
      logic [GEN_W-1:0]   gen;
   } entry_type;

   typedef struct packed {
      action_type                action;
      logic [KEY_W-1:0]          position_key;
      logic [DEPTH_W-1:0]        search_depth;
      logic signed [SCORE_W-1:0] score_value;
      kind_type                  bound_kind;
      logic [MOVE_W-1:0]         move_code;
      logic signed [SCORE_W-1:0] alpha_in;
      logic signed [SCORE_W-1:0] beta_in;
   } req_type;

endpackage

// ===== sv/transposition_table_probe_store.sv =====
// Direct-mapped transposition table: store, probe, new search, match move.
// Request channel req_* (valid/ready): one action with key, depth, score,
// bound kind, move and alpha/beta window. Response channel rsp_* (valid/ready):
// exactly one response per request, in order, with the window after a probe,
// probe hit, store collision and move match flags.
// The slot index is the key modulo TABLE_SLOTS. For a power-of-two table it
// is the low key bits and the slot read starts in the accept cycle, then the
// execute step registers the response. For any other size the remainder is
// built from the key a byte at a time, high byte first, each byte a reciprocal
// multiply step then a correcting subtract step, followed by the read step and
// the execute step. A request is accepted only once the last one has executed.
// Table entries live in one single-port-write,
// registered-read memory; each request does one read and at most one write,
// and the next read starts only after that write, so no forwarding is needed.
// Reset clears the generation and then runs a clearing pass that zeroes
// every slot in turn; req_ready stays low until it ends.
// The response sits in an output register. If the receiver stalls, the block
// still accepts one more request and finishes its table read, then holds
// that request until the pending response is taken.
module transposition_table_probe_store import ttps_pkg::*; #(
   parameter int TABLE_SLOTS = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic [KEY_W-1:0]          req_position_key,
   input  logic [DEPTH_W-1:0]        req_search_depth,
   input  logic signed [SCORE_W-1:0] req_score_value,
   input  logic [1:0]                req_bound_kind,
   input  logic [MOVE_W-1:0]         req_move_code,
   input  logic signed [SCORE_W-1:0] req_alpha_in,
   input  logic signed [SCORE_W-1:0] req_beta_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SCORE_W-1:0] rsp_alpha_out,
   output logic signed [SCORE_W-1:0] rsp_beta_out,
   output logic                      rsp_probe_hit,
   output logic                      rsp_collision_seen,
   output logic                      rsp_move_match
);

   localparam int  IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam bit  IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
   localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [31:0]      SLOTS_W32 = 32'(TABLE_SLOTS);
   localparam logic [31:0]      RECIP     = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [IDX_W-1:0]       rem_ff, rem_in;
   logic [CHUNK_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   phase_ff, phase_in;
   logic [7:0]             qest_ff, qest_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   logic [GEN_W-1:0]       gen_ff, gen_in;

   entry_type              slot_mem_ff [TABLE_SLOTS];
   entry_type              rdata_ff;
   entry_type              wdata;
   logic                   mem_we, mem_re;
   logic [IDX_W-1:0]       wr_addr, rd_addr;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SCORE_W-1:0] alpha_ff, alpha_in_nx, beta_ff, beta_in_nx;
   logic                   hit_ff, hit_in, coll_ff, coll_in, match_ff, match_in;

   logic                   accept, exec_go;
   logic [7:0]             div_chunk;
   logic [31:0]            div_x, div_qn, div_diff, div_rem;
   logic [63:0]            div_prod;
   logic                   key_eq, usable;
   logic signed [SCORE_W-1:0] stored_score;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // remainder step: r = (r * 256 + byte) mod TABLE_SLOTS, quotient estimate off by at most one
   assign div_chunk = req_ff.position_key[{~cnt_ff, 3'b000} +: 8];
   assign div_x     = 32'({rem_ff, div_chunk});
   assign div_prod  = {32'd0, div_x} * {32'd0, RECIP};
   assign div_qn    = {24'd0, qest_ff} * SLOTS_W32;
   assign div_diff  = div_x - div_qn;
   assign div_rem   = (div_diff >= SLOTS_W32) ? (div_diff - SLOTS_W32) : div_diff;

   assign key_eq       = (rdata_ff.key == req_ff.position_key);
   assign stored_score = rdata_ff.score;
   assign usable       = (rdata_ff.gen == gen_ff) && (rdata_ff.kind != KIND_NONE) &&
                         key_eq && (rdata_ff.depth >= req_ff.search_depth);

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      qest_in  = qest_ff;
      clr_in   = clr_ff;
      gen_in   = gen_ff;
      mem_re   = 1'b0;
      rd_addr  = rem_ff;
      mem_we   = 1'b0;
      wr_addr  = rem_ff;
      wdata    = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in.action       = action_type'(req_action);
               req_in.position_key = req_position_key;
               req_in.search_depth = req_search_depth;
               req_in.score_value  = req_score_value;
               req_in.bound_kind   = kind_type'(req_bound_kind);
               req_in.move_code    = req_move_code;
               req_in.alpha_in     = req_alpha_in;
               req_in.beta_in      = req_beta_in;
               cnt_in              = '0;
               phase_in            = 1'b0;
               if (IS_POW2) begin
                  rem_in   = req_position_key[IDX_W-1:0];
                  rd_addr  = req_position_key[IDX_W-1:0];
                  mem_re   = 1'b1;
                  state_in = ST_EXEC;
               end else begin
                  rem_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               qest_in  = div_prod[39:32];
            end else begin
               phase_in = 1'b0;
               rem_in   = div_rem[IDX_W-1:0];
               cnt_in   = cnt_ff + 1'b1;
               if (cnt_ff == '1) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
               if (req_ff.action == ACT_STORE) begin
                  mem_we      = 1'b1;
                  wdata.key   = req_ff.position_key;
                  wdata.score = req_ff.score_value;
                  wdata.kind  = req_ff.bound_kind;
                  wdata.mv    = req_ff.move_code;
                  wdata.depth = req_ff.search_depth;
                  wdata.gen   = gen_ff;
               end
               if (req_ff.action == ACT_NEW_SEARCH) begin
                  gen_in = gen_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      alpha_in_nx = req_ff.alpha_in;
      beta_in_nx  = req_ff.beta_in;
      hit_in      = 1'b0;
      coll_in     = 1'b0;
      match_in    = 1'b0;
      case (req_ff.action)
         ACT_STORE: begin
            coll_in = (rdata_ff.key != '0) && !key_eq;
         end
         ACT_PROBE: begin
            if (usable) begin
               hit_in = 1'b1;
               case (rdata_ff.kind)
                  KIND_EXACT: begin
                     alpha_in_nx = stored_score;
                     beta_in_nx  = stored_score;
                  end
                  KIND_LOWER: begin
                     if (stored_score > req_ff.alpha_in) begin
                        alpha_in_nx = stored_score;
                     end
                  end
                  default: begin
                     if (stored_score < req_ff.beta_in) begin
                        beta_in_nx = stored_score;
                     end
                  end
               endcase
            end
         end
         ACT_MATCH_MOVE: begin
            match_in = key_eq && (rdata_ff.mv == req_ff.move_code);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      qest_ff  <= qest_in;
      if (exec_go) begin
         alpha_ff <= alpha_in_nx;
         beta_ff  <= beta_in_nx;
         hit_ff   <= hit_in;
         coll_ff  <= coll_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[wr_addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alpha_out      = alpha_ff;
   assign rsp_beta_out       = beta_ff;
   assign rsp_probe_hit      = hit_ff;
   assign rsp_collision_seen = coll_ff;
   assign rsp_move_match     = match_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request accepted during clearing pass");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EXEC))
      else $error("response raised outside execute step");

   a_gen_step: assert property (@(posedge clock) disable iff (reset)
      (exec_go && req_ff.action == ACT_NEW_SEARCH) |=> (gen_ff == $past(gen_ff) + 8'd1))
      else $error("generation did not advance by one");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_EXEC) |-> ({1'b0, rem_ff} < SLOTS_EXT))
      else $error("slot index out of range");

   a_no_write_outside: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || (exec_go && req_ff.action == ACT_STORE)))
      else $error("table written outside clear or store");
`endif

endmodule
